[sv/gaps_pkg.sv]
// shared types, constants and move tables for the grid path search
// no dependencies
package gaps_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned GridSide = 64;
  localparam int unsigned CellW = 2 * CoordW;
  localparam int unsigned NCells = GridSide * GridSide;
  localparam int unsigned CostW = 14;
  localparam int unsigned LenW = 12;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdSearch = 2'd1;
  localparam logic [1:0] CmdRead = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              blocked;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] goal_x;
    logic [CoordW-1:0] goal_y;
    logic [LenW-1:0]   path_index;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [LenW-1:0]   path_length;
    logic [CoordW-1:0] step_x;
    logic [CoordW-1:0] step_y;
  } out_word_t;

  // per-cell search record
  typedef struct packed {
    logic             open;
    logic             closed;
    logic [CostW-1:0] cost;
    logic [2:0]       dir;
    logic [CellW-1:0] order;
  } cell_t;

  // scan unit control
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [CellW-1:0] addr;
  } scan_ctl_t;

  // move offsets as two-bit signed values, in expansion order
  function automatic logic [1:0] mv_dx(input logic [2:0] d);
    logic [1:0] r;
    unique case (d)
      3'd0, 3'd1: r = 2'b00;
      3'd2, 3'd6, 3'd7: r = 2'b01;
      default: r = 2'b11;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mv_dy(input logic [2:0] d);
    logic [1:0] r;
    unique case (d)
      3'd2, 3'd3: r = 2'b00;
      3'd1, 3'd5, 3'd6: r = 2'b01;
      default: r = 2'b11;
    endcase
    return r;
  endfunction

endpackage

[sv/gaps_ram.sv]
// generic single write port ram with registered read
// no dependencies
module gaps_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/gaps_scan.sv]
// open set scan: keeps the least f, then least h, then earliest inserted cell
// depends on gaps_pkg
module gaps_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gaps_pkg::scan_ctl_t         ctl_i,
  input  gaps_pkg::cell_t             word_i,
  input  logic [gaps_pkg::CoordW-1:0] goal_x_i,
  input  logic [gaps_pkg::CoordW-1:0] goal_y_i,
  output logic                        any_o,
  output logic [gaps_pkg::CellW-1:0]  best_addr_o,
  output gaps_pkg::cell_t             best_word_o
);
  import gaps_pkg::*;

  logic              any_q, any_d;
  logic [CellW-1:0]  addr_q, addr_d;
  cell_t             word_q, word_d;
  logic [CostW:0]    bf_q, bf_d;
  logic [CoordW:0]   bh_q, bh_d;
  logic [CoordW-1:0] cx, cy, ax, ay;
  logic [CoordW:0]   h;
  logic [CostW:0]    f;
  logic              better;

  // distance to goal and f of the incoming cell
  always_comb begin
    cx = ctl_i.addr[CoordW-1:0];
    cy = ctl_i.addr[CellW-1:CoordW];
    ax = (cx > goal_x_i) ? cx - goal_x_i : goal_x_i - cx;
    ay = (cy > goal_y_i) ? cy - goal_y_i : goal_y_i - cy;
    h = {1'b0, ax} + {1'b0, ay};
    f = {1'b0, word_i.cost} + {{(CostW - CoordW){1'b0}}, h};
    better = !any_q || (f < bf_q) || (f == bf_q && h < bh_q) ||
             (f == bf_q && h == bh_q && word_i.order < word_q.order);
  end

  // best candidate update
  always_comb begin
    any_d = any_q;
    addr_d = addr_q;
    word_d = word_q;
    bf_d = bf_q;
    bh_d = bh_q;
    if (ctl_i.clr) begin
      any_d = 1'b0;
    end else if (ctl_i.vld && word_i.open && better) begin
      any_d = 1'b1;
      addr_d = ctl_i.addr;
      word_d = word_i;
      bf_d = f;
      bh_d = h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else begin
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    word_q <= word_d;
    bf_q <= bf_d;
    bh_q <= bh_d;
  end

  assign any_o = any_q;
  assign best_addr_o = addr_q;
  assign best_word_o = word_q;

endmodule

[sv/grid_astar_path_search.sv]
// top level of the grid path search: command sequencer and cell memories
// depends on gaps_pkg, gaps_ram, gaps_scan
//
// channel | direction | handshake            | word
// in      | input     | in_valid_i/in_stall_o  | gaps_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i | gaps_pkg::out_word_t
//
// a search clears the cell memory, then each expansion scans all 4096 cells
// through the one memory read port, followed by neighbor updates in up to
// eight directions; the path walk then stores the path cell by cell.
// after reset the obstacle memory is swept to free, with no word accepted
// meanwhile. one word at a time; a waiting result stalls input.
module grid_astar_path_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gaps_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gaps_pkg::out_word_t out_word_o
);
  import gaps_pkg::*;

  localparam logic [3:0] SInit  = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SClr   = 4'd2;
  localparam logic [3:0] SStart = 4'd3;
  localparam logic [3:0] SScan  = 4'd4;
  localparam logic [3:0] STail  = 4'd5;
  localparam logic [3:0] SPick  = 4'd6;
  localparam logic [3:0] SObs   = 4'd7;
  localparam logic [3:0] SExpRd = 4'd8;
  localparam logic [3:0] SExpWr = 4'd9;
  localparam logic [3:0] SBpWr  = 4'd10;
  localparam logic [3:0] SBpMv  = 4'd11;
  localparam logic [3:0] SRd    = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [CellW-1:0]  cnt_q, cnt_d;
  logic [CellW-1:0]  seq_q, seq_d;
  logic [CellW-1:0]  s_q, s_d, g_q, g_d;
  logic [CellW-1:0]  n_q, n_d, c_q, c_d;
  logic [LenW-1:0]   j_q, j_d;
  logic [2:0]        d_q, d_d;
  logic [CostW-1:0]  bcost_q, bcost_d;
  logic              last_found_q, last_found_d;
  logic [LenW-1:0]   last_len_q, last_len_d;
  logic              rd_hit_q, rd_hit_d;
  logic              scan_vld_q, scan_vld_d;
  logic [CellW-1:0]  scan_addr_q, scan_addr_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic              obs_we, obs_wdata, obs_rdata;
  logic [CellW-1:0]  obs_waddr, obs_raddr;
  logic              cell_we;
  logic [CellW-1:0]  cell_waddr, cell_raddr;
  cell_t             cell_wdata, cell_rdata;
  logic              path_we;
  logic [CellW-1:0]  path_waddr, path_wdata, path_raddr, path_rdata;

  scan_ctl_t         scan_ctl;
  logic              best_any;
  logic [CellW-1:0]  best_addr;
  cell_t             best_word;

  logic              accept;
  logic [1:0]        dx, dy;
  logic [CoordW:0]   nx, ny;
  logic [CostW-1:0]  ng;
  logic [1:0]        pdx, pdy;
  logic [CoordW-1:0] px, py;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle) || out_valid_q;

  // neighbor of the best cell in the current direction
  always_comb begin
    dx = mv_dx(d_q);
    dy = mv_dy(d_q);
    nx = {1'b0, best_addr[CoordW-1:0]} + {{(CoordW - 1){dx[1]}}, dx};
    ny = {1'b0, best_addr[CellW-1:CoordW]} + {{(CoordW - 1){dy[1]}}, dy};
    ng = bcost_q + {{(CostW - 2){1'b0}}, 1'b0, dx[0]} + {{(CostW - 2){1'b0}}, 1'b0, dy[0]};
  end

  // parent of the path walk cell
  always_comb begin
    pdx = mv_dx(cell_rdata.dir);
    pdy = mv_dy(cell_rdata.dir);
    px = c_q[CoordW-1:0] - {{(CoordW - 2){pdx[1]}}, pdx};
    py = c_q[CellW-1:CoordW] - {{(CoordW - 2){pdy[1]}}, pdy};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    seq_d = seq_q;
    s_d = s_q;
    g_d = g_q;
    n_d = n_q;
    c_d = c_q;
    j_d = j_q;
    d_d = d_q;
    bcost_d = bcost_q;
    last_found_d = last_found_q;
    last_len_d = last_len_q;
    rd_hit_d = rd_hit_q;
    scan_vld_d = 1'b0;
    scan_addr_d = scan_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d = out_word_q;
    obs_we = 1'b0;
    obs_waddr = cnt_q;
    obs_wdata = 1'b0;
    obs_raddr = best_addr;
    cell_we = 1'b0;
    cell_waddr = cnt_q;
    cell_wdata = '0;
    cell_raddr = cnt_q;
    path_we = 1'b0;
    path_waddr = j_q;
    path_wdata = c_q;
    path_raddr = last_len_q - in_word_i.path_index;
    unique case (state_q)
      SInit: begin
        obs_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          out_word_d = '{found: last_found_q, path_length: last_len_q,
                         step_x: '0, step_y: '0};
          unique case (in_word_i.command)
            CmdWrite: begin
              obs_we = 1'b1;
              obs_waddr = {in_word_i.cell_y, in_word_i.cell_x};
              obs_wdata = in_word_i.blocked;
              out_valid_d = 1'b1;
            end
            CmdSearch: begin
              s_d = {in_word_i.start_y, in_word_i.start_x};
              g_d = {in_word_i.goal_y, in_word_i.goal_x};
              last_found_d = 1'b0;
              last_len_d = '0;
              cnt_d = '0;
              state_d = SClr;
            end
            CmdRead: begin
              rd_hit_d = last_found_q && (in_word_i.path_index <= last_len_q);
              state_d = SRd;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      SClr: begin
        cell_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = SStart;
        end
      end
      SStart: begin
        cell_we = 1'b1;
        cell_waddr = s_q;
        cell_wdata = '{open: 1'b1, closed: 1'b0, cost: '0, dir: '0, order: '0};
        seq_d = {{(CellW - 1){1'b0}}, 1'b1};
        cnt_d = '0;
        state_d = SScan;
      end
      SScan: begin
        scan_vld_d = 1'b1;
        scan_addr_d = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = STail;
        end
      end
      STail: begin
        state_d = SPick;
      end
      SPick: begin
        if (!best_any) begin
          out_word_d = '{found: 1'b0, path_length: '0, step_x: '0, step_y: '0};
          out_valid_d = 1'b1;
          state_d = SIdle;
        end else begin
          cell_we = 1'b1;
          cell_waddr = best_addr;
          cell_wdata = best_word;
          cell_wdata.open = 1'b0;
          cell_wdata.closed = 1'b1;
          bcost_d = best_word.cost;
          if (best_addr == g_q) begin
            c_d = g_q;
            j_d = '0;
            state_d = SBpWr;
          end else begin
            state_d = SObs;
          end
        end
      end
      SObs: begin
        d_d = '0;
        cnt_d = '0;
        state_d = obs_rdata ? SScan : SExpRd;
      end
      SExpRd: begin
        if (nx[CoordW] || ny[CoordW]) begin
          d_d = d_q + 1'b1;
          if (d_q == 3'd7) begin
            state_d = SScan;
          end
        end else begin
          cell_raddr = {ny[CoordW-1:0], nx[CoordW-1:0]};
          n_d = {ny[CoordW-1:0], nx[CoordW-1:0]};
          state_d = SExpWr;
        end
      end
      SExpWr: begin
        if (!cell_rdata.closed && (!cell_rdata.open || ng < cell_rdata.cost)) begin
          cell_we = 1'b1;
          cell_waddr = n_q;
          cell_wdata = '{open: 1'b1, closed: 1'b0, cost: ng, dir: d_q,
                         order: cell_rdata.open ? cell_rdata.order : seq_q};
          if (!cell_rdata.open) begin
            seq_d = seq_q + 1'b1;
          end
        end
        d_d = d_q + 1'b1;
        state_d = (d_q == 3'd7) ? SScan : SExpRd;
      end
      SBpWr: begin
        path_we = 1'b1;
        if (c_q == s_q || (&j_q)) begin
          last_found_d = 1'b1;
          last_len_d = j_q;
          out_word_d = '{found: 1'b1, path_length: j_q, step_x: '0, step_y: '0};
          out_valid_d = 1'b1;
          state_d = SIdle;
        end else begin
          cell_raddr = c_q;
          state_d = SBpMv;
        end
      end
      SBpMv: begin
        c_d = {py, px};
        j_d = j_q + 1'b1;
        state_d = SBpWr;
      end
      SRd: begin
        if (rd_hit_q) begin
          out_word_d.step_x = path_rdata[CoordW-1:0];
          out_word_d.step_y = path_rdata[CellW-1:CoordW];
        end
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign scan_ctl = '{clr: (state_q == SScan) && (cnt_q == '0),
                      vld: scan_vld_q, addr: scan_addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      cnt_q <= '0;
      last_found_q <= 1'b0;
      last_len_q <= '0;
      scan_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      last_found_q <= last_found_d;
      last_len_q <= last_len_d;
      scan_vld_q <= scan_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    s_q <= s_d;
    g_q <= g_d;
    n_q <= n_d;
    c_q <= c_d;
    j_q <= j_d;
    d_q <= d_d;
    bcost_q <= bcost_d;
    rd_hit_q <= rd_hit_d;
    scan_addr_q <= scan_addr_d;
    out_word_q <= out_word_d;
  end

  // obstacle map
  gaps_ram #(.Width(1), .Depth(NCells)) u_obs_ram (
    .clk_i  (clk_i),
    .we_i   (obs_we),
    .waddr_i(obs_waddr),
    .wdata_i(obs_wdata),
    .raddr_i(obs_raddr),
    .rdata_o(obs_rdata)
  );

  // per-cell search records
  gaps_ram #(.Width($bits(cell_t)), .Depth(NCells)) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_waddr),
    .wdata_i(cell_wdata),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  // path cells, stored goal first
  gaps_ram #(.Width(CellW), .Depth(NCells)) u_path_ram (
    .clk_i  (clk_i),
    .we_i   (path_we),
    .waddr_i(path_waddr),
    .wdata_i(path_wdata),
    .raddr_i(path_raddr),
    .rdata_o(path_rdata)
  );

  gaps_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .word_i     (cell_rdata),
    .goal_x_i   (g_q[CoordW-1:0]),
    .goal_y_i   (g_q[CellW-1:CoordW]),
    .any_o      (best_any),
    .best_addr_o(best_addr),
    .best_word_o(best_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == SIdle)
    else $error("word accepted while busy");
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != SIdle) || out_valid_q)
    else $error("accepted word left no trace");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !last_found_q |-> last_len_q == '0)
    else $error("length kept without a found path");
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SInit |-> in_stall_o && !out_valid_q)
    else $error("input open during map clear");
`endif

endmodule

[dv/grid_astar_path_search_tb.sv]
// self-checking testbench for the grid path search block
// needs gaps_pkg and grid_astar_path_search; holds its own A* predictor
`timescale 1ns / 1ps

module grid_astar_path_search_tb;
  import gaps_pkg::*;

  localparam int NumRandom = 84;
  localparam int WatchLimit = 2_500_000;
  localparam int MaxExpand = 150;
  localparam int StepX [8] = '{0, 0, 1, -1, -1, -1, 1, 1};
  localparam int StepY [8] = '{-1, 1, 0, 0, -1, 1, 1, -1};

  typedef struct {
    in_word_t  word;
    out_word_t want;
    bit        drain;
  } job_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  grid_astar_path_search dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  bit          map_blk [NCells];
  int          g_cost  [NCells];
  int          from_dir[NCells];
  bit          is_open [NCells];
  bit          is_done [NCells];
  int          ins_seq [NCells];
  int          route   [NCells];
  bit          have_path;
  int          route_len;

  job_t        pending_q[$];
  out_word_t   result_q[$];
  int          n_words, n_results, n_bad, n_search, n_found, idle_cnt;
  bit          stim_done, taken;

  // A* over the obstacle map; returns expansions, commits the path when asked
  function automatic int astar(int sx, int sy, int gx, int gy, bit commit);
    int  s, g, seq, exps, best, bf, bh, bo, h, f, nx, ny, n, ng, c, len, d, k;
    bit  any;
    if (commit) begin
      have_path = 0;
      route_len = 0;
    end
    for (c = 0; c < NCells; c++) begin
      is_open[c] = 0;
      is_done[c] = 0;
    end
    s = sy * GridSide + sx;
    g = gy * GridSide + gx;
    g_cost[s] = 0;
    is_open[s] = 1;
    ins_seq[s] = 0;
    seq = 1;
    exps = 0;
    forever begin
      any = 0;
      best = 0; bf = 0; bh = 0; bo = 0;
      // least f, then least h, then oldest
      for (c = 0; c < NCells; c++) begin
        if (!is_open[c]) continue;
        h = ((c % GridSide) > gx ? (c % GridSide) - gx : gx - (c % GridSide)) +
            ((c / GridSide) > gy ? (c / GridSide) - gy : gy - (c / GridSide));
        f = g_cost[c] + h;
        if (!any || f < bf || (f == bf && h < bh) ||
            (f == bf && h == bh && ins_seq[c] < bo)) begin
          any = 1; best = c; bf = f; bh = h; bo = ins_seq[c];
        end
      end
      if (!any) return exps;
      exps++;
      is_open[best] = 0;
      is_done[best] = 1;
      if (best == g) begin
        if (commit) begin
          // walk parents back to the start, then store from the start
          c = g; len = 0;
          while (c != s) begin
            d = from_dir[c];
            c = (c / GridSide - StepY[d]) * GridSide + (c % GridSide - StepX[d]);
            len++;
          end
          c = g;
          for (k = len; k >= 0; k--) begin
            route[k] = c;
            if (k > 0) begin
              d = from_dir[c];
              c = (c / GridSide - StepY[d]) * GridSide + (c % GridSide - StepX[d]);
            end
          end
          have_path = 1;
          route_len = len > 4095 ? 4095 : len;
        end
        return exps;
      end
      if (map_blk[best]) continue;
      for (d = 0; d < 8; d++) begin
        nx = best % GridSide + StepX[d];
        ny = best / GridSide + StepY[d];
        if (nx < 0 || ny < 0 || nx >= GridSide || ny >= GridSide) continue;
        n = ny * GridSide + nx;
        if (is_done[n]) continue;
        ng = g_cost[best] + (StepX[d] != 0) + (StepY[d] != 0);
        if (!is_open[n] || ng < g_cost[n]) begin
          g_cost[n] = ng;
          from_dir[n] = d;
          if (!is_open[n]) begin
            is_open[n] = 1;
            ins_seq[n] = seq++;
          end
        end
      end
    end
  endfunction

  function automatic out_word_t predict_status(in_word_t w);
    out_word_t r;
    int        c;
    r = '0;
    case (w.command)
      CmdWrite: map_blk[w.cell_y * GridSide + w.cell_x] = w.blocked;
      CmdSearch: void'(astar(w.start_x, w.start_y, w.goal_x, w.goal_y, 1'b1));
      CmdRead: begin
        if (have_path && w.path_index <= route_len) begin
          c = route[w.path_index];
          r.step_x = CoordW'(c % GridSide);
          r.step_y = CoordW'(c / GridSide);
        end
      end
      default: ;
    endcase
    r.found = have_path;
    r.path_length = LenW'(route_len);
    return r;
  endfunction

  task automatic add_job(in_word_t w, bit drain);
    job_t j;
    j.word = w;
    j.drain = drain;
    j.want = predict_status(w);
    if (w.command == CmdSearch) begin
      n_search++;
      n_found += j.want.found;
    end
    pending_q.push_back(j);
  endtask

  function automatic in_word_t noise_word(logic [1:0] cmd);
    in_word_t    w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.command = cmd;
    return w;
  endfunction

  task automatic add_write(int x, int y, bit blk);
    in_word_t w;
    w = noise_word(CmdWrite);
    w.cell_x = CoordW'(x); w.cell_y = CoordW'(y); w.blocked = blk;
    add_job(w, 1'b0);
  endtask

  task automatic add_search(int sx, int sy, int gx, int gy);
    in_word_t w;
    w = noise_word(CmdSearch);
    w.start_x = CoordW'(sx); w.start_y = CoordW'(sy);
    w.goal_x = CoordW'(gx); w.goal_y = CoordW'(gy);
    add_job(w, 1'b0);
  endtask

  task automatic add_read(int idx, bit drain);
    in_word_t w;
    w = noise_word(CmdRead);
    w.path_index = LenW'(idx);
    add_job(w, drain);
  endtask

  // stimulus: directed corners first, then a random mix
  initial begin
    int i, sel, sx, sy, gx, gy, tries, lo;
    add_read(0, 1'b0);
    add_job(noise_word(2'd3), 1'b0);
    add_write(1, 0, 1'b1);
    add_write(0, 1, 1'b1);
    add_write(1, 1, 1'b1);
    add_search(0, 0, 5, 5);               // start walled in, no route
    add_read(0, 1'b0);
    add_search(63, 63, 63, 63);           // start on goal
    add_read(0, 1'b0);
    add_read(1, 1'b0);
    add_write(62, 62, 1'b1);
    add_search(63, 63, 60, 60);           // detour around a blocked diagonal
    add_read(0, 1'b0);
    add_read(2, 1'b0);
    add_read(4095, 1'b0);
    add_write(1, 0, 1'b0);
    add_write(0, 1, 1'b0);
    add_write(1, 1, 1'b0);
    add_write(62, 62, 1'b0);
    add_search(0, 0, 2, 3);
    add_read(route_len, 1'b1);            // sender holds until results drain
    for (i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if ($urandom_range(0, 3) == 0)
          add_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else
          add_write($urandom_range(20, 35), $urandom_range(20, 35),
                    $urandom_range(0, 2) == 0);
      end else if (sel < 62) begin
        // keep goals close so each search stays short
        for (tries = 0; tries < 8; tries++) begin
          lo = ($urandom_range(0, 2) == 0) ? 0 : 20;
          sx = (lo == 0) ? $urandom_range(0, 63) : $urandom_range(20, 35);
          sy = (lo == 0) ? $urandom_range(0, 63) : $urandom_range(20, 35);
          gx = sx + $urandom_range(0, 6) - 3;
          gy = sy + $urandom_range(0, 6) - 3;
          gx = gx < 0 ? 0 : (gx > 63 ? 63 : gx);
          gy = gy < 0 ? 0 : (gy > 63 ? 63 : gy);
          if (astar(sx, sy, gx, gy, 1'b0) <= MaxExpand) break;
        end
        if (tries == 8) begin
          gx = sx;
          gy = sy;
        end
        add_search(sx, sy, gx, gy);
      end else if (sel < 95) begin
        if ($urandom_range(0, 3) == 0) add_read($urandom_range(0, 4095), 1'b0);
        else add_read($urandom_range(0, route_len + 1), 1'b0);
      end else begin
        add_job(noise_word(2'd3), 1'b0);
      end
    end
    stim_done = 1;
  end

  // reset
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // word acceptance on the input side
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      result_q.push_back(pending_q[0].want);
      void'(pending_q.pop_front());
      n_words++;
      taken = 1;
    end
  end

  // driver: new word or idle at the falling edge
  always @(negedge clk_i) begin
    int total, s_idle, r_idle;
    total = n_words + pending_q.size();
    if (n_words < total / 3) begin
      s_idle = 6; r_idle = 54;
    end else if (n_words < 2 * total / 3) begin
      s_idle = 54; r_idle = 6;
    end else begin
      s_idle = 0; r_idle = 0;
    end
    out_stall_i <= ($urandom_range(0, 99) < r_idle);
    if (rst_ni && (!in_valid_i || taken)) begin
      if (pending_q.size() == 0 || (pending_q[0].drain && result_q.size() != 0) ||
          $urandom_range(0, 99) < s_idle) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_word_i <= pending_q[0].word;
      end
    end
    taken = 0;
  end

  // result check against the oldest expected status
  always @(posedge clk_i) begin
    out_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %p", out_word_o);
      end else begin
        want = result_q.pop_front();
        n_results++;
        if (out_word_o.found !== want.found ||
            out_word_o.path_length !== want.path_length ||
            out_word_o.step_x !== want.step_x || out_word_o.step_y !== want.step_y) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d: expected found=%0d len=%0d step=(%0d,%0d) got %0d %0d (%0d,%0d)",
                     n_results, want.found, want.path_length, want.step_x, want.step_y,
                     out_word_o.found, out_word_o.path_length,
                     out_word_o.step_x, out_word_o.step_y);
        end
      end
    end
  end

  // watchdog on progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WatchLimit) begin
      $display("timeout with %0d words pending", pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done && pending_q.size() == 0 && result_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("%0d words, %0d searches (%0d found a route), %0d results checked",
             n_words, n_search, n_found, n_results);
    if (n_bad == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
